@@ design/serial_command_line_dispatcher_core_assert.svh @@
// Assertion macros for the serial command line dispatcher.
// Used by the top level only; relies on nothing else.
`ifndef SERIAL_COMMAND_LINE_DISPATCHER_CORE_ASSERT_SVH
`define SERIAL_COMMAND_LINE_DISPATCHER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCLD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("scld assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define SCLD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scld assertion failed (next cycle)");

`endif

@@ design/scld_pkg.sv @@
// Shared types and constants for the serial command line dispatcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package scld_pkg;

  // Parameter defaults
  localparam int unsigned MAX_COMMANDS_DEF = 8;
  localparam int unsigned NAME_LEN_DEF     = 8;
  localparam int unsigned LINE_LEN_DEF     = 64;

  // Width of a name as it travels through the queue
  localparam int unsigned TEXT_W = 64;
  // Wide enough for an entry count up to 16
  localparam int unsigned ENTRY_CNT_MAX_W = 5;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_SEL_PREFIX  = 1'b0;
  localparam logic REG_SEL_DEFAULT = 1'b1;

  // Characters with special meaning
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Request kinds (tuser)
  localparam logic REQ_BYTE     = 1'b0;
  localparam logic REQ_REGISTER = 1'b1;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_RUN        = 3'd1,
    KIND_DEFAULT    = 3'd2,
    KIND_REGISTERED = 3'd3,
    KIND_FULL       = 3'd4
  } result_kind_e;

  // One operation for the back end: a registration or a line dispatch.
  // flag: handler present (registration) or token too long (dispatch).
  typedef struct packed {
    logic              is_reg;
    logic              flag;
    logic [TEXT_W-1:0] text;
  } scld_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } scld_q_status_t;

  typedef struct packed {
    logic [ENTRY_CNT_MAX_W-1:0] entry_count;
  } scld_back_status_t;

endpackage

`default_nettype wire

@@ design/scld_front.sv @@
// Front end: line assembly, prefix filtering and token capture.
// Uses scld_pkg; emits registrations and line dispatches to the queue.
`default_nettype none

module scld_front
  import scld_pkg::*;
#(
  parameter int unsigned NAME_LEN = NAME_LEN_DEF,
  parameter int unsigned LINE_LEN = LINE_LEN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        prefix_i,
  input  wire logic              fire_i,
  input  wire logic              req_type_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [TEXT_W-1:0] name_text_i,
  input  wire logic              handler_present_i,
  output logic                   push_o,
  output scld_op_t               op_o
);

  localparam int unsigned TOK_W = 8 * NAME_LEN;
  localparam int unsigned LC_W  = $clog2(LINE_LEN + 1);
  localparam int unsigned TL_W  = $clog2(NAME_LEN + 2);

  logic [LC_W-1:0]  line_count_q, line_count_d;
  logic [TOK_W-1:0] token_text_q, token_text_d;
  logic [TL_W-1:0]  token_length_q, token_length_d;
  logic             token_closed_q, token_closed_d;

  logic             is_byte;
  logic             keep;
  logic             push;
  scld_op_t         op;
  logic [TOK_W-1:0] trimmed;
  logic             stop;

  // Trim a name at its first zero byte
  always_comb begin
    trimmed = '0;
    stop    = 1'b0;
    for (int j = 0; j < NAME_LEN; j++) begin
      if (!stop) begin
        if (name_text_i[8*j +: 8] == CHAR_NUL) begin
          stop = 1'b1;
        end else begin
          trimmed[8*j +: 8] = name_text_i[8*j +: 8];
        end
      end
    end
  end

  // Next line state and the operation to enqueue
  always_comb begin
    is_byte        = (req_type_i == REQ_BYTE);
    line_count_d   = line_count_q;
    token_text_d   = token_text_q;
    token_length_d = token_length_q;
    token_closed_d = token_closed_q;
    push           = 1'b0;
    op.is_reg      = 1'b1;
    op.flag        = handler_present_i;
    op.text        = TEXT_W'(trimmed);
    keep           = 1'b0;

    if (!is_byte) begin
      push = 1'b1;
    end else begin
      // full line without newline: discard it
      if (line_count_q == LC_W'(LINE_LEN)) begin
        line_count_d   = '0;
        token_text_d   = '0;
        token_length_d = '0;
        token_closed_d = 1'b0;
      end
      keep = !((line_count_d == '0) && (prefix_i != CHAR_NUL) && (rx_byte_i != prefix_i))
             && (rx_byte_i != CHAR_CR);
      if (keep) begin
        if (rx_byte_i == CHAR_LF) begin
          push           = 1'b1;
          op.is_reg      = 1'b0;
          op.flag        = (token_length_d > TL_W'(NAME_LEN));
          op.text        = TEXT_W'(token_text_d);
          line_count_d   = '0;
          token_text_d   = '0;
          token_length_d = '0;
          token_closed_d = 1'b0;
        end else begin
          // the stored prefix byte is not part of the token
          if (!((line_count_d == '0) && (prefix_i != CHAR_NUL)) && !token_closed_d) begin
            if ((rx_byte_i == CHAR_SPACE) || (rx_byte_i == CHAR_NUL)) begin
              token_closed_d = 1'b1;
            end else if (token_length_d < TL_W'(NAME_LEN)) begin
              for (int j = 0; j < NAME_LEN; j++) begin
                if (TL_W'(j) == token_length_d) begin
                  token_text_d[8*j +: 8] = rx_byte_i;
                end
              end
              token_length_d = token_length_d + 1'b1;
            end else begin
              token_length_d = TL_W'(NAME_LEN + 1);
            end
          end
          line_count_d = line_count_d + 1'b1;
        end
      end
    end
  end

  // Line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q   <= '0;
      token_text_q   <= '0;
      token_length_q <= '0;
      token_closed_q <= 1'b0;
    end else if (fire_i && is_byte) begin
      line_count_q   <= line_count_d;
      token_text_q   <= token_text_d;
      token_length_q <= token_length_d;
      token_closed_q <= token_closed_d;
    end
  end

  assign push_o = fire_i && push;
  assign op_o   = op;

endmodule

`default_nettype wire

@@ design/scld_queue.sv @@
// Two-entry queue of operations between front and back end.
// Uses scld_pkg for the operation and status types.
`default_nettype none

module scld_queue
  import scld_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire scld_op_t op_i,
  input  wire logic  pop_i,
  output scld_op_t   head_o,
  output scld_q_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  scld_op_t         entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  // Pointer and fill level update
  always_comb begin
    do_push  = push_i && (count_q != CNT_W'(QUEUE_DEPTH));
    do_pop   = pop_i && (count_q != '0);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

  assign head_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ design/scld_back.sv @@
// Back end: name table, registration and parallel token match.
// Uses scld_pkg; drives the registered result stage.
`default_nettype none

module scld_back
  import scld_pkg::*;
#(
  parameter int unsigned MAX_COMMANDS = MAX_COMMANDS_DEF,
  parameter int unsigned NAME_LEN     = NAME_LEN_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   default_present_i,
  input  wire scld_op_t op_i,
  input  wire logic   op_valid_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output result_kind_e kind_o,
  output logic [2:0]  index_o,
  output scld_back_status_t status_o
);

  localparam int unsigned TOK_W = 8 * NAME_LEN;
  localparam int unsigned CNT_W = $clog2(MAX_COMMANDS + 1);
  localparam int unsigned IDX_W = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;

  logic [TOK_W-1:0]    name_q [MAX_COMMANDS];
  logic [MAX_COMMANDS-1:0] handler_q;
  logic [CNT_W-1:0]    entry_count_q;

  logic                out_valid_q;
  result_kind_e        kind_q, kind_d;
  logic [2:0]          index_q, index_d;

  logic [TOK_W-1:0]    tok;
  logic [MAX_COMMANDS-1:0] hit;
  logic                found;
  logic [IDX_W-1:0]    match_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic                table_full;
  logic                pop;
  logic [IDX_W+2:0]    idx_ext;

  assign tok        = op_i.text[TOK_W-1:0];
  assign table_full = (entry_count_q == CNT_W'(MAX_COMMANDS));
  assign wr_idx     = entry_count_q[IDX_W-1:0];
  assign pop        = op_valid_i && (!out_valid_q || out_ready_i);

  // Compare the token with every stored name at once
  always_comb begin
    for (int i = 0; i < MAX_COMMANDS; i++) begin
      hit[i] = (CNT_W'(i) < entry_count_q) && (name_q[i] == tok);
    end
  end

  // First matching entry wins
  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    for (int i = 0; i < MAX_COMMANDS; i++) begin
      if (hit[i] && !found) begin
        found     = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  // Result selection
  always_comb begin
    idx_ext = '0;
    kind_d  = default_present_i ? KIND_DEFAULT : KIND_NONE;
    if (op_i.is_reg) begin
      if (table_full) begin
        kind_d = KIND_FULL;
      end else begin
        kind_d  = KIND_REGISTERED;
        idx_ext = {3'b000, wr_idx};
      end
    end else if (!op_i.flag && found && handler_q[match_idx]) begin
      kind_d  = KIND_RUN;
      idx_ext = {3'b000, match_idx};
    end
    index_d = idx_ext[2:0];
  end

  // Table storage, written on registration only
  always_ff @(posedge clk_i) begin
    if (pop && op_i.is_reg && !table_full) begin
      name_q[wr_idx] <= tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      handler_q     <= '0;
      entry_count_q <= '0;
    end else if (pop && op_i.is_reg && !table_full) begin
      handler_q[wr_idx] <= op_i.flag;
      entry_count_q     <= entry_count_q + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      kind_q  <= kind_d;
      index_q <= index_d;
    end
  end

  assign pop_o                = pop;
  assign out_valid_o          = out_valid_q;
  assign kind_o               = kind_q;
  assign index_o              = index_q;
  assign status_o.entry_count = ENTRY_CNT_MAX_W'(entry_count_q);

endmodule

`default_nettype wire

@@ design/serial_command_line_dispatcher_core.sv @@
// Top level of the serial command line dispatcher: APB registers and stream ports.
// Uses scld_pkg, scld_front, scld_queue, scld_back and the assertion macro header.
`default_nettype none

// Takes one request per clock while the queue has room: a received byte or a
// command name registration. Bytes build lines; on a newline the first token
// is matched against all registered names in parallel, which sets the rate:
// one request per cycle while results are taken. The front end writes the
// operation of an accepted request into a two-entry queue, and the back end
// then registers its result. While a result waits, two more operations fit
// in the queue; then the request side stalls. Bytes that do not end a line
// give no result. Configuration (prefix at 0x0, default handler flag at 0x4)
// is for the user to write only while idle; the block does not enforce it.

`include "serial_command_line_dispatcher_core_assert.svh"

module serial_command_line_dispatcher_core
  import scld_pkg::*;
#(
  parameter int unsigned MAX_COMMANDS = MAX_COMMANDS_DEF,
  parameter int unsigned NAME_LEN     = NAME_LEN_DEF,
  parameter int unsigned LINE_LEN     = LINE_LEN_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // APB configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] rx_byte, [71:8] name_text, [72] handler_present, [79:73] zero
  input  wire logic [79:0]           s_axis_tdata,
  // [0] req_type
  input  wire logic                  s_axis_tuser,
  // Result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [2:0] result_kind, [5:3] entry_index, [7:6] zero
  output logic [7:0]                 m_axis_tdata
);

  logic [7:0]        prefix_q;
  logic              default_present_q;
  logic              cfg_wr;
  logic              s_fire;
  logic              q_push;
  logic              q_pop;
  scld_op_t          front_op;
  scld_op_t          q_head;
  scld_q_status_t    q_status;
  scld_back_status_t back_status;
  result_kind_e      kind;
  logic [2:0]        index;
  logic              in_reg;
  logic              in_lf;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q          <= '0;
      default_present_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SEL_PREFIX:  prefix_q          <= pwdata[7:0];
        REG_SEL_DEFAULT: default_present_q <= pwdata[0];
        default:         prefix_q          <= prefix_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SEL_PREFIX:  prdata = {24'b0, prefix_q};
      REG_SEL_DEFAULT: prdata = {31'b0, default_present_q};
      default:         prdata = '0;
    endcase
  end

  // Input transaction: accept whenever the queue has room
  assign s_axis_tready = !q_status.full;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  scld_front #(
    .NAME_LEN (NAME_LEN),
    .LINE_LEN (LINE_LEN)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .prefix_i          (prefix_q),
    .fire_i            (s_fire),
    .req_type_i        (s_axis_tuser),
    .rx_byte_i         (s_axis_tdata[7:0]),
    .name_text_i       (s_axis_tdata[71:8]),
    .handler_present_i (s_axis_tdata[72]),
    .push_o            (q_push),
    .op_o              (front_op)
  );

  scld_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .op_i     (front_op),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  scld_back #(
    .MAX_COMMANDS (MAX_COMMANDS),
    .NAME_LEN     (NAME_LEN)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .default_present_i (default_present_q),
    .op_i              (q_head),
    .op_valid_i        (!q_status.empty),
    .pop_o             (q_pop),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .kind_o            (kind),
    .index_o           (index),
    .status_o          (back_status)
  );

  assign m_axis_tdata = {2'b00, index, kind};

  // Checks
  assign in_reg = s_fire && (s_axis_tuser == REQ_REGISTER);
  assign in_lf  = s_fire && (s_axis_tuser == REQ_BYTE) && (s_axis_tdata[7:0] == CHAR_LF);

  `SCLD_ASSERT_SAME(a_reg_enqueued, clk_i, rst_ni, in_reg, q_push)
  `SCLD_ASSERT_SAME(a_lf_enqueued, clk_i, rst_ni, in_lf && (prefix_q == CHAR_NUL), q_push)
  `SCLD_ASSERT_NEXT(a_pop_gives_result, clk_i, rst_ni, q_pop, m_axis_tvalid)
  `SCLD_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, back_status.entry_count <= ENTRY_CNT_MAX_W'(MAX_COMMANDS))

endmodule

`default_nettype wire

@@ test/serial_command_line_dispatcher_core_tb.sv @@
// Self-checking testbench for serial_command_line_dispatcher_core.
// Drives the request stream and the APB port and scores every result against a predictor.
// Depends on scld_pkg and the block itself; reads no files.
`default_nettype none

module serial_command_line_dispatcher_core_tb;
  import scld_pkg::*;

  localparam int unsigned MAX_CMD     = MAX_COMMANDS_DEF;
  localparam int unsigned NAME_CHARS  = NAME_LEN_DEF;
  localparam int unsigned LINE_CHARS  = LINE_LEN_DEF;
  localparam int          TARGET_REQS = 1050;
  localparam int          NUM_PHASES  = 6;
  // Extra wait after the last expected result, as a margin.
  localparam int          DRAIN_CYCLES = 8;

  localparam logic [APB_ADDR_W-1:0] ADDR_PREFIX  = {REG_SEL_PREFIX, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_DEFAULT = {REG_SEL_DEFAULT, 2'b00};

  typedef struct {
    result_kind_e kind;
    logic [2:0]   index;
  } dispatch_result_t;

  // Shadow of the command table and line parser; queues the result each
  // accepted request should produce and scores results as they come out.
  class dispatch_scoreboard;
    logic [63:0]      names[MAX_CMD];
    bit               has_handler[MAX_CMD];
    int               n_entries;
    int               line_fill;
    logic [63:0]      tok_text;
    int               tok_len;
    bit               tok_closed;
    logic [7:0]       prefix;
    bit               dflt;
    dispatch_result_t pending_results[$];
    int               errors;
    int               kind_count[5];

    function new();
      n_entries = 0;
      prefix    = 8'h00;
      dflt      = 1'b0;
      errors    = 0;
      foreach (has_handler[i]) has_handler[i] = 1'b0;
      foreach (kind_count[i]) kind_count[i] = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_fill  = 0;
      tok_text   = '0;
      tok_len    = 0;
      tok_closed = 1'b0;
    endfunction

    function void expect_result(result_kind_e kind, logic [2:0] index);
      dispatch_result_t r;
      r.kind  = kind;
      r.index = index;
      pending_results.push_back(r);
    endfunction

    // Token lookup at end of line: first name that matches decides.
    function void dispatch_line();
      int hit;
      hit = -1;
      if (tok_len <= NAME_CHARS) begin
        for (int i = 0; i < n_entries; i++) begin
          if (names[i] == tok_text) begin
            hit = i;
            break;
          end
        end
      end
      if (hit >= 0 && has_handler[hit]) expect_result(KIND_RUN, hit[2:0]);
      else expect_result(dflt ? KIND_DEFAULT : KIND_NONE, 3'd0);
    endfunction

    function void note_request(logic is_reg, logic [7:0] rx, logic [63:0] text, logic hp);
      logic [63:0] kept;
      int          pos;
      kept = '0;
      if (is_reg == REQ_REGISTER) begin
        if (n_entries >= MAX_CMD) begin
          expect_result(KIND_FULL, 3'd0);
          return;
        end
        for (int i = 0; i < NAME_CHARS; i++) begin
          if (text[8*i +: 8] == CHAR_NUL) break;
          kept[8*i +: 8] = text[8*i +: 8];
        end
        names[n_entries]       = kept;
        has_handler[n_entries] = hp;
        expect_result(KIND_REGISTERED, n_entries[2:0]);
        n_entries++;
        return;
      end
      // Received byte
      if (line_fill >= LINE_CHARS) clear_line();
      if (line_fill == 0 && prefix != 8'h00 && rx != prefix) return;
      if (rx == CHAR_CR) return;
      pos = line_fill;
      line_fill++;
      if (rx == CHAR_LF) begin
        dispatch_line();
        clear_line();
        return;
      end
      // prefix byte itself is not part of the token
      if (pos == 0 && prefix != 8'h00) return;
      if (!tok_closed) begin
        if (rx == CHAR_SPACE || rx == CHAR_NUL) begin
          tok_closed = 1'b1;
        end else if (tok_len < NAME_CHARS) begin
          tok_text[8*tok_len +: 8] = rx;
          tok_len++;
        end else begin
          tok_len = NAME_CHARS + 1;
        end
      end
    endfunction

    function void check_result(logic [7:0] data);
      dispatch_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: data 0x%02h", data);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (data[2:0] != exp_r.kind) begin
        $error("result_kind: expected %0d, got %0d", exp_r.kind, data[2:0]);
        errors++;
      end
      if (data[5:3] != exp_r.index) begin
        $error("entry_index: expected %0d, got %0d", exp_r.index, data[5:3]);
        errors++;
      end
      if (data[7:6] != 2'b00) begin
        $error("padding: expected 0, got %0d", data[7:6]);
        errors++;
      end
      if (exp_r.kind <= KIND_FULL) kind_count[exp_r.kind]++;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [7:0] rx_byte, [71:8] name_text, [72] handler_present, [79:73] zero
  logic [79:0]           s_axis_tdata;
  // [0] req_type
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [2:0] result_kind, [5:3] entry_index, [7:6] zero
  logic [7:0]            m_axis_tdata;

  dispatch_scoreboard sb;
  int items_sent;
  int configs_used;
  int src_calm;
  int sink_calm;

  serial_command_line_dispatcher_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Gap length: mostly none or short, now and then long, with calm stretches.
  function automatic int idle_len(ref int calm_left);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (roll < 3) begin
      calm_left = $urandom_range(30, 100);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result sink with random back-pressure
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    sink_calm     = 0;
    forever begin
      @(negedge clk_i);
      stall = idle_len(sink_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // One request transaction; entered and left just after a falling edge.
  task automatic push_request(logic is_reg, logic [7:0] rx, logic [63:0] text, logic hp);
    int gap;
    gap = idle_len(src_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= is_reg;
    s_axis_tdata  <= {7'b0, hp, text, rx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(is_reg, rx, text, hp);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Unused fields carry random values so they are seen to be ignored.
  task automatic send_byte(logic [7:0] b);
    push_request(REQ_BYTE, b, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_name(logic [63:0] text, logic hp);
    push_request(REQ_REGISTER, 8'($urandom_range(0, 255)), text, hp);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [63:0] pack_name(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // Wait until every expected result is out and the pipeline is quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic program_register(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_PREFIX) begin
      want      = {24'b0, value[7:0]};
      sb.prefix = value[7:0];
    end else begin
      want    = {31'b0, value[0]};
      sb.dflt = value[0];
    end
    if (readback != want) begin
      $error("prdata: expected 0x%08h, got 0x%08h", want, readback);
      sb.errors++;
    end
  endtask

  task automatic apply_config(logic [7:0] pfx, logic dflt_on);
    program_register(ADDR_PREFIX, {16'($urandom_range(0, 16'hffff)), 8'h00, pfx});
    program_register(ADDR_DEFAULT, {16'($urandom_range(0, 16'hffff)), 15'h0, dflt_on});
    configs_used++;
  endtask

  // Well-formed line with random content, sometimes with noise or a CR.
  task automatic random_line();
    logic [7:0]  bytes_q[$];
    logic [63:0] nm;
    int          roll;
    int          len;
    int          pick;
    if (sb.prefix != 8'h00 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) bytes_q.push_back(8'($urandom_range(0, 255)));
    end
    if (sb.prefix != 8'h00) bytes_q.push_back(sb.prefix);
    roll = $urandom_range(0, 99);
    if (roll < 60 && sb.n_entries > 0) begin
      pick = $urandom_range(0, sb.n_entries - 1);
      nm   = sb.names[pick];
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
      for (int i = 0; i < len; i++) begin
        if (nm[8*i +: 8] == CHAR_NUL) break;
        bytes_q.push_back(nm[8*i +: 8]);
      end
    end else if (roll < 80) begin
      repeat ($urandom_range(0, 10)) bytes_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
    end else if (roll < 88) begin
      repeat ($urandom_range(9, 12)) bytes_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
    end else begin
      repeat ($urandom_range(0, 6)) bytes_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0) begin
      bytes_q.insert($urandom_range(0, bytes_q.size()), CHAR_CR);
    end
    if ($urandom_range(0, 2) == 0) begin
      bytes_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NUL);
      repeat ($urandom_range(0, 6)) bytes_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
    end
    bytes_q.push_back(CHAR_LF);
    foreach (bytes_q[i]) send_byte(bytes_q[i]);
  endtask

  task automatic random_registration();
    logic [63:0] text;
    int          roll;
    int          len;
    roll = $urandom_range(0, 99);
    text = {$urandom, $urandom};
    if (roll < 50) begin
      // short printable name, junk after the terminator
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) text[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7e));
      if (len < 8) text[8*len +: 8] = CHAR_NUL;
    end else if (roll < 70 && sb.n_entries > 0) begin
      text = sb.names[$urandom_range(0, sb.n_entries - 1)];
    end
    send_name(text, 1'($urandom_range(0, 1)));
  endtask

  // Line without a newline of LINE_LEN - 4 to LINE_LEN + 6 random bytes, often running past LINE_LEN.
  task automatic overflow_line();
    logic [7:0] b;
    if (sb.prefix != 8'h00) send_byte(sb.prefix);
    repeat ($urandom_range(LINE_CHARS - 4, LINE_CHARS + 6)) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_LF) b = 8'h41;
      send_byte(b);
    end
  endtask

  // Run limit
  initial begin
    #(20_000_000);
    $display("serial_command_line_dispatcher_core_tb: FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    logic [7:0] phase_prefix[NUM_PHASES];
    logic       phase_dflt[NUM_PHASES];
    int         phase_end;
    int         roll;
    sb            = new();
    items_sent    = 0;
    configs_used  = 0;
    src_calm      = 0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_BYTE;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: registrations incl. empty, duplicate and all-ones names
    send_name(pack_name("go"), 1'b1);
    send_name(64'h1234_5678_9abc_de00, 1'b1);
    send_name(pack_name("stop"), 1'b0);
    send_name(pack_name("go"), 1'b0);
    send_name({64{1'b1}}, 1'b1);
    send_text("go");
    send_byte(CHAR_LF);
    send_byte(CHAR_LF);                 // empty token hits empty name
    send_text("stop");
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);                 // no handler, default absent
    repeat (8) send_byte(8'hff);
    send_byte(CHAR_LF);
    send_text("go");
    send_byte(CHAR_NUL);                // zero byte closes the token
    send_text("x");
    send_byte(CHAR_LF);
    settle();
    apply_config(8'h00, 1'b1);
    send_text("stop");
    send_byte(CHAR_LF);
    send_text("abcdefghi");             // too long to match anything
    send_byte(CHAR_LF);
    settle();
    apply_config("!", 1'b1);
    send_text("go");
    send_byte(CHAR_LF);                 // dropped: no line open
    send_text("!go arg");
    send_byte(CHAR_LF);
    settle();
    apply_config(CHAR_LF, 1'b0);
    send_byte(CHAR_LF);                 // opens and ends the line at once
    settle();

    // Random phases over several settings, extremes included
    phase_prefix = '{8'h00, 8'hff, "!", CHAR_LF, 8'h00, 8'h00};
    phase_dflt   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_prefix[4] = 8'($urandom_range(1, 255));
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_config(phase_prefix[p], phase_dflt[p]);
      phase_end = items_sent + (TARGET_REQS - items_sent) / (NUM_PHASES - p);
      while (items_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) random_line();
        else if (roll < 80) random_registration();
        else if (roll < 92) repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        else overflow_line();
      end
      settle();
    end

    $display("Sent %0d requests under %0d register settings; results: %0d run, %0d default,",
             items_sent, configs_used, sb.kind_count[KIND_RUN], sb.kind_count[KIND_DEFAULT]);
    $display("  %0d no action, %0d registered, %0d table full.", sb.kind_count[KIND_NONE],
             sb.kind_count[KIND_REGISTERED], sb.kind_count[KIND_FULL]);
    if (sb.errors == 0) begin
      $display("serial_command_line_dispatcher_core_tb: PASS");
    end else begin
      $display("serial_command_line_dispatcher_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/scld_pkg.sv
design/scld_front.sv
design/scld_queue.sv
design/scld_back.sv
design/serial_command_line_dispatcher_core.sv
test/serial_command_line_dispatcher_core_tb.sv
